/* rtl/assert_macros.svh */
// Assertion macros shared by the heap queue RTL.
// Needs clk and rst_n in the scope of the file that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define HPQ_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("heap queue check failed");

// Same-cycle implication.
`define HPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap queue implication failed");

`else

`define HPQ_ASSERT(lbl, expr)
`define HPQ_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

/* rtl/hpq_pkg.sv */
// Package for the binary max-heap priority queue: sizes, entry type and codes.
// No dependencies.
package hpq_pkg;

  localparam int CAPACITY      = 64;
  localparam int PRIORITY_BITS = 8;
  localparam int TAG_BITS      = 16;

  localparam int IDX_W = $clog2(CAPACITY);       // store address
  localparam int CNT_W = $clog2(CAPACITY + 1);   // 0..CAPACITY
  localparam int CH_W  = IDX_W + 2;              // 2*pos+2 fits

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

endpackage

/* rtl/binary_max_heap_priority_queue.sv */
// Binary max-heap priority queue: top level with its heap store RAM.
// Depends on hpq_pkg and assert_macros.svh.
//
//   channel  ports                                              direction
//   in       in_valid in_stall in_op in_new_priority in_new_tag  to block
//   out      out_valid out_stall out_status out_priority         from block
//            out_tag out_fill_count
//
// One item at a time. Each heap level costs a RAM read then a compare-and-write.
// Insert: places the new entry at the end and climbs level by level to its place.
// Extract: reads root and last entry, then sinks the last one unless it emptied; refusals go to S_RESP.
// Reset clears state, count and out_valid only; data above the count is never used.
// A finished result sits in the output register; the next item is taken while
// it waits, and the block holds its next result until that register frees up.
`include "assert_macros.svh"

module binary_max_heap_priority_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [hpq_pkg::PRIORITY_BITS-1:0]  in_new_priority,
  input  logic [hpq_pkg::TAG_BITS-1:0]       in_new_tag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [hpq_pkg::PRIORITY_BITS-1:0]  out_priority,
  output logic [hpq_pkg::TAG_BITS-1:0]       out_tag,
  output logic [hpq_pkg::CNT_W-1:0]          out_fill_count
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_RD  = 8'b0000_0010,
    S_INS_CMP = 8'b0000_0100,
    S_EXT_RD  = 8'b0000_1000,
    S_EXT_LD  = 8'b0001_0000,
    S_SNK_RD  = 8'b0010_0000,
    S_SNK_CMP = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  hpq_pkg::entry_t               item_r, item_nxt;
  logic [hpq_pkg::IDX_W-1:0]     pos_r, pos_nxt;
  logic [hpq_pkg::CNT_W-1:0]     count_r, count_nxt;
  hpq_pkg::status_t              res_status_r, res_status_nxt;
  hpq_pkg::entry_t               res_entry_r, res_entry_nxt;
  logic                          r_ok_r, r_ok_nxt;

  logic                          out_valid_r;
  hpq_pkg::status_t              out_status_r;
  hpq_pkg::entry_t               out_entry_r;
  logic [hpq_pkg::CNT_W-1:0]     out_fill_r;
  logic                          out_load;

  // heap store: one write port, two read ports, registered read data
  hpq_pkg::entry_t               heap_mem [hpq_pkg::CAPACITY];
  logic                          mem_we;
  logic [hpq_pkg::IDX_W-1:0]     mem_wa, mem_ra, mem_rb;
  hpq_pkg::entry_t               mem_wd, rda_r, rdb_r;

  logic [hpq_pkg::IDX_W-1:0]     parent;
  logic [hpq_pkg::CH_W-1:0]      l_idx, r_idx, cnt_ext;
  logic                          take_l, take_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    rda_r <= heap_mem[mem_ra];
    rdb_r <= heap_mem[mem_rb];
  end

  assign parent  = (pos_r - hpq_pkg::IDX_W'(1)) >> 1;
  assign l_idx   = {1'b0, pos_r, 1'b1};
  assign r_idx   = l_idx + hpq_pkg::CH_W'(1);
  assign cnt_ext = hpq_pkg::CH_W'(count_r);

  // larger child wins only on strictly greater priority; left wins ties
  assign take_l = rda_r.prio > item_r.prio;
  assign take_r = r_ok_r && (rdb_r.prio > (take_l ? rda_r.prio : item_r.prio));

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    r_ok_nxt       = r_ok_r;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = item_r;
    mem_ra         = parent;
    mem_rb         = r_idx[hpq_pkg::IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = '{prio: in_new_priority, tag: in_new_tag};
          res_status_nxt = hpq_pkg::ST_DONE;
          res_entry_nxt  = '0;
          if (in_op == hpq_pkg::OP_INSERT) begin
            if (count_r == hpq_pkg::CNT_W'(hpq_pkg::CAPACITY)) begin
              res_status_nxt = hpq_pkg::ST_FULL;
              state_nxt      = S_RESP;
            end else begin
              pos_nxt   = count_r[hpq_pkg::IDX_W-1:0];
              count_nxt = count_r + hpq_pkg::CNT_W'(1);
              state_nxt = S_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = hpq_pkg::ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              count_nxt = count_r - hpq_pkg::CNT_W'(1);
              state_nxt = S_EXT_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rda_r.prio >= item_r.prio) begin
          state_nxt = S_RESP;
        end else begin
          // parent moves down into the hole, hole moves up
          mem_wd    = rda_r;
          pos_nxt   = parent;
          state_nxt = S_INS_RD;
        end
      end
      S_EXT_RD: begin
        mem_ra    = '0;
        mem_rb    = count_r[hpq_pkg::IDX_W-1:0];   // last entry, count already dropped
        state_nxt = S_EXT_LD;
      end
      S_EXT_LD: begin
        res_entry_nxt = rda_r;
        item_nxt      = rdb_r;
        pos_nxt       = '0;
        state_nxt     = (count_r == '0) ? S_RESP : S_SNK_RD;
      end
      S_SNK_RD: begin
        mem_ra = l_idx[hpq_pkg::IDX_W-1:0];
        if (l_idx >= cnt_ext) begin
          mem_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          r_ok_nxt  = r_idx < cnt_ext;
          state_nxt = S_SNK_CMP;
        end
      end
      S_SNK_CMP: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wd    = rdb_r;
          pos_nxt   = r_idx[hpq_pkg::IDX_W-1:0];
          state_nxt = S_SNK_RD;
        end else if (take_l) begin
          mem_wd    = rda_r;
          pos_nxt   = l_idx[hpq_pkg::IDX_W-1:0];
          state_nxt = S_SNK_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    r_ok_r       <= r_ok_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_entry_r  <= res_entry_r;
      out_fill_r   <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_priority   = out_entry_r.prio;
  assign out_tag        = out_entry_r.tag;
  assign out_fill_count = out_fill_r;

  `HPQ_ASSERT(a_count_bound, count_r <= hpq_pkg::CNT_W'(hpq_pkg::CAPACITY))
  `HPQ_ASSERT_IMP(a_full_count, out_valid && (out_status == hpq_pkg::ST_FULL),
                  out_fill_count == hpq_pkg::CNT_W'(hpq_pkg::CAPACITY))
  `HPQ_ASSERT_IMP(a_empty_count, out_valid && (out_status == hpq_pkg::ST_EMPTY),
                  out_fill_count == '0)
  `HPQ_ASSERT_IMP(a_climb_not_root, state_r == S_INS_CMP, pos_r != '0)

endmodule

/* tb/sv/hpq_checker.sv */
`timescale 1ns / 100ps
// Checker for the heap priority queue: watches both channels, keeps its own heap
// and compares each result transfer with the oldest prediction. Needs hpq_pkg.
module hpq_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_op,
  input  logic [hpq_pkg::PRIORITY_BITS-1:0] in_new_priority,
  input  logic [hpq_pkg::TAG_BITS-1:0]      in_new_tag,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [1:0]                        out_status,
  input  logic [hpq_pkg::PRIORITY_BITS-1:0] out_priority,
  input  logic [hpq_pkg::TAG_BITS-1:0]      out_tag,
  input  logic [hpq_pkg::CNT_W-1:0]         out_fill_count,
  output int                                fail_count,
  output int                                pending,
  output int                                results_seen,
  output int                                full_refusals,
  output int                                empty_refusals,
  output int                                peak_fill
);

  typedef struct packed {
    hpq_pkg::status_t                  status;
    logic [hpq_pkg::PRIORITY_BITS-1:0] prio;
    logic [hpq_pkg::TAG_BITS-1:0]      tag;
    logic [hpq_pkg::CNT_W-1:0]         fill;
  } heap_result_t;

  heap_result_t     expected_results[$];
  hpq_pkg::entry_t  heap_model[hpq_pkg::CAPACITY];
  int               held;

  function automatic void swap_entries(int a, int b);
    hpq_pkg::entry_t t;
    t = heap_model[a];
    heap_model[a] = heap_model[b];
    heap_model[b] = t;
  endfunction

  // sift up; an equal parent stops the climb so older entries stay ahead
  function automatic void climb(int pos);
    int  up;
    bit  done;
    done = 1'b0;
    while (pos > 0 && !done) begin
      up = (pos - 1) / 2;
      if (heap_model[up].prio >= heap_model[pos].prio) begin
        done = 1'b1;
      end else begin
        swap_entries(up, pos);
        pos = up;
      end
    end
  endfunction

  // sift down; strict compares keep the left child on ties
  function automatic void settle(int pos);
    int  l;
    int  r;
    int  best;
    bit  done;
    done = 1'b0;
    while (!done) begin
      l = 2 * pos + 1;
      r = l + 1;
      best = pos;
      if (l < held && heap_model[l].prio > heap_model[best].prio) best = l;
      if (r < held && heap_model[r].prio > heap_model[best].prio) best = r;
      if (best == pos) begin
        done = 1'b1;
      end else begin
        swap_entries(pos, best);
        pos = best;
      end
    end
  endfunction

  function automatic heap_result_t apply_heap_op(logic op,
                                                 logic [hpq_pkg::PRIORITY_BITS-1:0] p,
                                                 logic [hpq_pkg::TAG_BITS-1:0] t);
    heap_result_t res;
    res = '0;
    res.status = hpq_pkg::ST_DONE;
    if (op == hpq_pkg::OP_INSERT) begin
      if (held >= hpq_pkg::CAPACITY) begin
        res.status = hpq_pkg::ST_FULL;
      end else begin
        heap_model[held].prio = p;
        heap_model[held].tag  = t;
        climb(held);
        held++;
      end
    end else if (held == 0) begin
      res.status = hpq_pkg::ST_EMPTY;
    end else begin
      res.prio = heap_model[0].prio;
      res.tag  = heap_model[0].tag;
      heap_model[0] = heap_model[held - 1];
      held--;
      if (held > 0) settle(0);
    end
    res.fill = hpq_pkg::CNT_W'(held);
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    heap_result_t want;
    heap_result_t got;
    if (!rst_n) begin
      held = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_heap_op(in_op, in_new_priority, in_new_tag));
        if (held > peak_fill) peak_fill = held;
      end
      if (out_valid && !out_stall) begin
        got = {hpq_pkg::status_t'(out_status), out_priority, out_tag, out_fill_count};
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: status %0d prio %0h tag %0h fill %0d",
                   $time, out_status, out_priority, out_tag, out_fill_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          if (want.status == hpq_pkg::ST_FULL) full_refusals++;
          if (want.status == hpq_pkg::ST_EMPTY) empty_refusals++;
          if (got !== want) begin
            $display("%0t: mismatch: expected status %0d prio %0h tag %0h fill %0d",
                     $time, want.status, want.prio, want.tag, want.fill);
            $display("%0t:           actual status %0d prio %0h tag %0h fill %0d",
                     $time, out_status, out_priority, out_tag, out_fill_count);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* tb/sv/binary_max_heap_priority_queue_tb.sv */
`timescale 1ns / 100ps
// Top of the heap priority queue testbench: clock, reset, stimulus and verdict.
// Needs hpq_pkg, the block and hpq_checker.
module binary_max_heap_priority_queue_tb;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_op = hpq_pkg::OP_INSERT;
  logic [hpq_pkg::PRIORITY_BITS-1:0] in_new_priority = '0;
  logic [hpq_pkg::TAG_BITS-1:0]      in_new_tag = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [1:0]                        out_status;
  logic [hpq_pkg::PRIORITY_BITS-1:0] out_priority;
  logic [hpq_pkg::TAG_BITS-1:0]      out_tag;
  logic [hpq_pkg::CNT_W-1:0]         out_fill_count;

  int  fail_count;
  int  pending;
  int  results_seen;
  int  full_refusals;
  int  empty_refusals;
  int  peak_fill;

  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_cycles = 0;
  int   stall_pct = 0;
  int   mode_left = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  int   random_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  binary_max_heap_priority_queue i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_new_priority(in_new_priority),
    .in_new_tag     (in_new_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_priority   (out_priority),
    .out_tag        (out_tag),
    .out_fill_count (out_fill_count)
  );

  hpq_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_new_priority(in_new_priority),
    .in_new_tag     (in_new_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_priority   (out_priority),
    .out_tag        (out_tag),
    .out_fill_count (out_fill_count),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals),
    .peak_fill      (peak_fill)
  );

  // result side: random stall modes, plus a long hold-off whenever the toggle flips
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_cycles = 400;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_op(input logic op, input logic [hpq_pkg::PRIORITY_BITS-1:0] p,
                         input logic [hpq_pkg::TAG_BITS-1:0] t);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_new_priority <= p;
    in_new_tag      <= t;
    do @(posedge clk); while (in_stall);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int  seg;
    int  insert_pct;
    int  span;
    logic op;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty refusal, field extremes, equal priorities in arrival order
    send_op(hpq_pkg::OP_EXTRACT, '0, '0);
    send_op(hpq_pkg::OP_INSERT, 8'h00, 16'h0000);
    send_op(hpq_pkg::OP_INSERT, 8'hFF, 16'hFFFF);
    send_op(hpq_pkg::OP_INSERT, 8'h80, 16'h1111);
    send_op(hpq_pkg::OP_INSERT, 8'h80, 16'h2222);
    send_op(hpq_pkg::OP_INSERT, 8'h7F, 16'hAAAA);
    send_op(hpq_pkg::OP_INSERT, 8'h80, 16'h3333);
    send_op(hpq_pkg::OP_INSERT, 8'h01, 16'h5555);
    repeat (8) send_op(hpq_pkg::OP_EXTRACT, 8'hFF, 16'hFFFF);
    // sift-down tie: the left child of equal priority wins
    send_op(hpq_pkg::OP_INSERT, 8'h32, 16'h0001);
    send_op(hpq_pkg::OP_INSERT, 8'h28, 16'h0002);
    send_op(hpq_pkg::OP_INSERT, 8'h28, 16'h0003);
    send_op(hpq_pkg::OP_INSERT, 8'h1E, 16'h0004);
    repeat (4) send_op(hpq_pkg::OP_EXTRACT, 8'h00, 16'h0000);
    wait_drained();

    // fill past capacity while results are held back, then drain past empty
    hold_toggle <= ~hold_toggle;
    gaps_on = 1'b0;
    repeat (hpq_pkg::CAPACITY + 2)
      send_op(hpq_pkg::OP_INSERT, 8'($urandom_range(255)), 16'($urandom));
    gaps_on = 1'b1;
    repeat (hpq_pkg::CAPACITY + 2)
      send_op(hpq_pkg::OP_EXTRACT, 8'($urandom_range(255)), 16'($urandom));
    wait_drained();

    // random segments biased toward filling, draining or churning
    while (random_sent < 2000) begin
      seg = $urandom_range(10, 120);
      case ($urandom_range(2))
        0: insert_pct = 85;
        1: insert_pct = 50;
        default: insert_pct = 15;
      endcase
      case ($urandom_range(3))
        0: span = 3;
        1: span = 15;
        default: span = 255;
      endcase
      if (random_sent > 1000 && hold_toggle == hold_seen && $urandom_range(9) == 0)
        hold_toggle <= ~hold_toggle;
      repeat (seg) begin
        op = ($urandom_range(99) < insert_pct) ? hpq_pkg::OP_INSERT : hpq_pkg::OP_EXTRACT;
        send_op(op, 8'($urandom_range(span)), 16'($urandom));
        random_sent++;
      end
    end
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Run covered %0d results, %0d full and %0d empty refusals, peak fill %0d of %0d",
             results_seen, full_refusals, empty_refusals, peak_fill, hpq_pkg::CAPACITY);
    if (fail_count == 0 && pending == 0) begin
      $display("binary_max_heap_priority_queue verification clean");
    end else begin
      $display("binary_max_heap_priority_queue verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("binary_max_heap_priority_queue verification failed");
    $finish;
  end

endmodule
